@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that cons holds in the same cycle as ante
`define NCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that cons holds in the cycle after ante
`define NCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/nce_pkg.sv @@
// Package: opcode groups, RAM write controls and helper functions
package nce_pkg;

  // Upper opcode nibble groups
  localparam logic [3:0] OP_JCN = 4'h1;
  localparam logic [3:0] OP_FIM = 4'h2;
  localparam logic [3:0] OP_FIN = 4'h3;
  localparam logic [3:0] OP_JUN = 4'h4;
  localparam logic [3:0] OP_JMS = 4'h5;
  localparam logic [3:0] OP_INC = 4'h6;
  localparam logic [3:0] OP_ISZ = 4'h7;
  localparam logic [3:0] OP_ADD = 4'h8;
  localparam logic [3:0] OP_SUB = 4'h9;
  localparam logic [3:0] OP_LD  = 4'hA;
  localparam logic [3:0] OP_XCH = 4'hB;
  localparam logic [3:0] OP_BBL = 4'hC;
  localparam logic [3:0] OP_LDM = 4'hD;
  localparam logic [3:0] OP_IO  = 4'hE;
  localparam logic [3:0] OP_ACC = 4'hF;

  // I/O and RAM group, low nibble
  localparam logic [3:0] IO_WRM = 4'h0;
  localparam logic [3:0] IO_WMP = 4'h1;
  localparam logic [3:0] IO_WRR = 4'h2;
  localparam logic [3:0] IO_WPM = 4'h3;
  localparam logic [3:0] IO_WR0 = 4'h4;
  localparam logic [3:0] IO_WR3 = 4'h7;
  localparam logic [3:0] IO_SBM = 4'h8;
  localparam logic [3:0] IO_RDM = 4'h9;
  localparam logic [3:0] IO_RDR = 4'hA;
  localparam logic [3:0] IO_ADM = 4'hB;

  // Accumulator group, low nibble
  localparam logic [3:0] AC_CLB = 4'h0;
  localparam logic [3:0] AC_CLC = 4'h1;
  localparam logic [3:0] AC_IAC = 4'h2;
  localparam logic [3:0] AC_CMC = 4'h3;
  localparam logic [3:0] AC_CMA = 4'h4;
  localparam logic [3:0] AC_RAL = 4'h5;
  localparam logic [3:0] AC_RAR = 4'h6;
  localparam logic [3:0] AC_TCC = 4'h7;
  localparam logic [3:0] AC_DAC = 4'h8;
  localparam logic [3:0] AC_TCS = 4'h9;
  localparam logic [3:0] AC_STC = 4'hA;
  localparam logic [3:0] AC_DAA = 4'hB;
  localparam logic [3:0] AC_KBP = 4'hC;
  localparam logic [3:0] AC_DCL = 4'hD;

  // Fetch phases
  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_FIN    = 2'd2;
  localparam logic [1:0] PH_WPM    = 2'd3;

  // RAM write strobes from the execute logic
  typedef struct packed {
    logic dwe;
    logic swe;
  } ram_wr_t;

  // 4-bit add, returns {carry, sum}
  function automatic logic [4:0] add4(logic [4:0] a, logic [3:0] b, logic c);
    logic [5:0] s;
    s = {1'b0, a} + {2'b00, b} + {5'b0, c};
    return s[4:0];
  endfunction

  // Keyboard decode: one-hot to index, else 15
  function automatic logic [3:0] kbp(logic [3:0] a);
    logic [3:0] r;
    case (a)
      4'd0: r = 4'd0;
      4'd1: r = 4'd1;
      4'd2: r = 4'd2;
      4'd4: r = 4'd3;
      4'd8: r = 4'd4;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/nce_ifs.sv @@
// Channel interfaces: input word, result word, configuration write
interface nce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rom_byte;
  logic       test_level;
  logic [3:0] rom_port_in;
  modport source (output valid, rom_byte, test_level, rom_port_in, input ready);
  modport sink (input valid, rom_byte, test_level, rom_port_in, output ready);
endinterface

interface nce_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rom_address;
  logic        instruction_done;
  logic        ram_port_write;
  logic [4:0]  ram_port_index;
  logic        rom_port_write;
  logic [3:0]  rom_port_index;
  logic [3:0]  port_data;
  logic        rom_write;
  logic [15:0] rom_write_address;
  logic [7:0]  rom_write_data;
  logic [3:0]  accumulator;
  logic        carry;
  modport source (output valid, rom_address, instruction_done, ram_port_write,
                  ram_port_index, rom_port_write, rom_port_index, port_data, rom_write,
                  rom_write_address, rom_write_data, accumulator, carry, input ready);
  modport sink (input valid, rom_address, instruction_done, ram_port_write,
                ram_port_index, rom_port_write, rom_port_index, port_data, rom_write,
                rom_write_address, rom_write_data, accumulator, carry, output ready);
endinterface

interface nce_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/nibble_cpu_instruction_executor_core.sv @@
// Top level: 4-bit processor core executing one program byte per word
//
//   channel | dir | payload
//   in_ch   | in  | rom_byte, test_level, rom_port_in
//   out_ch  | out | next rom_address, strobes, accumulator, carry
//   cfg_ch  | in  | program_write_base (16 bit)
//
// A word is captured into the input register together with the RAM read, then executed into the result register.
// The data/status RAM read is synchronous, so it is registered together with the capture.
// After reset a sweep clears the RAM_BANKS*256 data entries and the status entries before in_ch.ready rises.
// A stalled result holds the execute step; the next word is taken once it executes.
module nibble_cpu_instruction_executor_core #(
  parameter int STACK_DEPTH = 4,
  parameter int RAM_BANKS   = 8
) (
  input logic   clk,
  input logic   rst_n,
  nce_in_if.sink    in_ch,
  nce_out_if.source out_ch,
  nce_cfg_if.sink   cfg_ch
);
  import nce_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int DA_W = $clog2(RAM_BANKS * 256);
  localparam int SA_W = $clog2(RAM_BANKS * 64);

  // Architectural state
  logic [15:0]     base_r;
  logic [11:0]     pc_r, pc_nxt;
  logic [11:0]     stk_r [STACK_DEPTH];
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [3:0]      ix_r [16];
  logic [3:0]      ix_nxt [16];
  logic [3:0]      acc_r, acc_nxt;
  logic            cy_r, cy_nxt;
  logic [7:0]      src_r, src_nxt;
  logic [2:0]      bank_r, bank_nxt;
  logic            wnt_r, wnt_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [7:0]      hop_r, hop_nxt;

  // Input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       it_r;
  logic [3:0] ip_r;

  // Execute controls
  logic            push;
  logic            go;
  logic            accept;
  logic            busy;
  ram_wr_t         wr;
  logic [3:0]      d_q, s_q;
  logic [DA_W-1:0] d_addr;
  logic [SA_W-1:0] s_addr;
  logic [1:0]      s_lo;
  logic [2:0]      beff;

  // Result word fields
  logic [15:0] addr;
  logic        done, rampw, rompw, romw;
  logic [3:0]  pdata;
  logic [15:0] romwa;
  logic [7:0]  romwd;

  // Bank modulo RAM_BANKS over a 3-bit value
  function automatic logic [2:0] bank_mod(logic [2:0] b);
    logic [3:0] v;
    v = {1'b0, b};
    for (int i = 0; i < 8; i++) begin
      if (v >= 4'(RAM_BANKS)) v = v - 4'(RAM_BANKS);
    end
    return v[2:0];
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !iv_r && !busy;
  assign go = iv_r && (!out_ch.valid || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // RAM addresses follow the state, low status bits from the opcode being taken
  assign beff = bank_mod(bank_r);
  assign s_lo = iv_r ? ib_r[1:0] : in_ch.rom_byte[1:0];
  assign d_addr = DA_W'({beff, src_r});
  assign s_addr = SA_W'({beff, src_r[7:4], s_lo});

  nce_ram #(.RAM_BANKS(RAM_BANKS)) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .d_addr  (d_addr),
    .s_addr  (s_addr),
    .wr      (wr),
    .wr_data (acc_r),
    .d_q     (d_q),
    .s_q     (s_q),
    .busy    (busy)
  );

  // Execute one word
  always_comb begin
    logic [11:0] pc1;
    logic [3:0]  lo;
    logic [3:0]  pe;
    logic [4:0]  s;
    logic        cond;
    pc_nxt = pc_r;
    sp_nxt = sp_r;
    ix_nxt = ix_r;
    acc_nxt = acc_r;
    cy_nxt = cy_r;
    src_nxt = src_r;
    bank_nxt = bank_r;
    wnt_nxt = wnt_r;
    ph_nxt = PH_OPCODE;
    hop_nxt = hop_r;
    push = 1'b0;
    wr = '0;
    done = 1'b1;
    rampw = 1'b0;
    rompw = 1'b0;
    romw = 1'b0;
    pdata = 4'd0;
    romwa = 16'd0;
    romwd = 8'd0;
    pc1 = pc_r + 12'd1;
    s = 5'd0;
    cond = 1'b0;
    addr = 16'd0;
    case (ph_r)
      PH_OPCODE: begin
        lo = ib_r[3:0];
        pe = {lo[3:1], 1'b0};
        pc_nxt = pc1;
        hop_nxt = ib_r;
        addr = {4'd0, pc1};
        case (ib_r[7:4])
          OP_JCN, OP_JUN, OP_JMS, OP_ISZ: begin
            ph_nxt = PH_SECOND;
            done = 1'b0;
          end
          OP_FIM: begin
            if (lo[0]) src_nxt = {ix_r[pe], ix_r[pe | 4'd1]};
            else begin
              ph_nxt = PH_SECOND;
              done = 1'b0;
            end
          end
          OP_FIN: begin
            if (lo[0]) begin
              pc_nxt = {pc1[11:8], ix_r[pe], ix_r[pe | 4'd1]};
              addr = {4'd0, pc_nxt};
            end else begin
              ph_nxt = PH_FIN;
              done = 1'b0;
              addr = {4'd0, pc1[11:8], ix_r[0], ix_r[1]};
            end
          end
          OP_INC: ix_nxt[lo] = ix_r[lo] + 4'd1;
          OP_ADD: begin
            s = add4({1'b0, acc_r}, ix_r[lo], cy_r);
            {cy_nxt, acc_nxt} = s;
          end
          OP_SUB: begin
            s = add4({1'b0, acc_r}, ~ix_r[lo], ~cy_r);
            {cy_nxt, acc_nxt} = s;
          end
          OP_LD: acc_nxt = ix_r[lo];
          OP_XCH: begin
            acc_nxt = ix_r[lo];
            ix_nxt[lo] = acc_r;
          end
          OP_BBL: begin
            acc_nxt = lo;
            sp_nxt = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
            pc_nxt = stk_r[sp_nxt];
            addr = {4'd0, pc_nxt};
          end
          OP_LDM: acc_nxt = lo;
          OP_IO: begin
            case (lo) inside
              IO_WRM: wr.dwe = go;
              IO_WMP: begin
                rampw = 1'b1;
                pdata = acc_r;
              end
              IO_WRR: begin
                rompw = 1'b1;
                pdata = acc_r;
              end
              IO_WPM: begin
                ph_nxt = PH_WPM;
                done = 1'b0;
                addr = base_r + {8'd0, src_r};
              end
              [IO_WR0:IO_WR3]: wr.swe = go;
              IO_SBM: begin
                s = add4({1'b0, acc_r}, ~d_q, ~cy_r);
                {cy_nxt, acc_nxt} = s;
              end
              IO_RDM: acc_nxt = d_q;
              IO_RDR: acc_nxt = ip_r;
              IO_ADM: begin
                s = add4({1'b0, acc_r}, d_q, cy_r);
                {cy_nxt, acc_nxt} = s;
              end
              default: acc_nxt = s_q;
            endcase
          end
          OP_ACC: begin
            case (lo)
              AC_CLB: begin
                acc_nxt = 4'd0;
                cy_nxt = 1'b0;
              end
              AC_CLC: cy_nxt = 1'b0;
              AC_IAC: begin
                s = add4({1'b0, acc_r}, 4'd1, 1'b0);
                {cy_nxt, acc_nxt} = s;
              end
              AC_CMC: cy_nxt = ~cy_r;
              AC_CMA: acc_nxt = ~acc_r;
              AC_RAL: begin
                s = add4({acc_r, 1'b0}, {3'd0, cy_r}, 1'b0);
                {cy_nxt, acc_nxt} = s;
              end
              AC_RAR: begin
                cy_nxt = acc_r[0];
                acc_nxt = {cy_r, acc_r[3:1]};
              end
              AC_TCC: begin
                acc_nxt = {3'd0, cy_r};
                cy_nxt = 1'b0;
              end
              AC_DAC: begin
                s = add4({1'b0, acc_r}, 4'd15, 1'b0);
                {cy_nxt, acc_nxt} = s;
              end
              AC_TCS: begin
                acc_nxt = 4'd9 + {3'd0, cy_r};
                cy_nxt = 1'b0;
              end
              AC_STC: cy_nxt = 1'b1;
              AC_DAA: begin
                if (cy_r || acc_r > 4'd9) begin
                  s = {1'b0, acc_r} + 5'd6;
                  acc_nxt = s[3:0];
                  if (s[4]) cy_nxt = 1'b1;
                end
              end
              AC_KBP: acc_nxt = kbp(acc_r);
              AC_DCL: bank_nxt = acc_r[2:0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      PH_SECOND: begin
        lo = hop_r[3:0];
        pe = {lo[3:1], 1'b0};
        pc_nxt = pc1;
        case (hop_r[7:4])
          OP_JCN: begin
            if (lo[0] && !it_r) cond = 1'b1;
            if (lo[1] && cy_r) cond = 1'b1;
            if (lo[2] && acc_r == 4'd0) cond = 1'b1;
            if (lo[3]) cond = !cond;
            if (cond) pc_nxt = {pc1[11:8], ib_r};
          end
          OP_FIM: begin
            ix_nxt[pe] = ib_r[7:4];
            ix_nxt[pe | 4'd1] = ib_r[3:0];
          end
          OP_JUN: pc_nxt = {lo, ib_r};
          OP_JMS: begin
            push = 1'b1;
            sp_nxt = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
            pc_nxt = {lo, ib_r};
          end
          default: begin
            ix_nxt[lo] = ix_r[lo] + 4'd1;
            if (ix_nxt[lo] != 4'd0) pc_nxt = {pc1[11:8], ib_r};
          end
        endcase
        addr = {4'd0, pc_nxt};
      end
      PH_FIN: begin
        lo = hop_r[3:0];
        pe = {lo[3:1], 1'b0};
        ix_nxt[pe] = ib_r[7:4];
        ix_nxt[pe | 4'd1] = ib_r[3:0];
        addr = {4'd0, pc_r};
      end
      default: begin
        lo = hop_r[3:0];
        pe = 4'd0;
        romwd = wnt_r ? {ib_r[7:4], acc_r} : {acc_r, ib_r[3:0]};
        wnt_nxt = ~wnt_r;
        romw = 1'b1;
        romwa = base_r + {8'd0, src_r};
        addr = {4'd0, pc_r};
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= 16'd0;
    else if (cfg_ch.valid && cfg_ch.ready) base_r <= cfg_ch.data;
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (accept) iv_r <= 1'b1;
    else if (go) iv_r <= 1'b0;
    if (accept) begin
      ib_r <= in_ch.rom_byte;
      it_r <= in_ch.test_level;
      ip_r <= in_ch.rom_port_in;
    end
  end

  // Advance the architectural state on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 12'd0;
      sp_r <= '0;
      acc_r <= 4'd0;
      cy_r <= 1'b0;
      src_r <= 8'd0;
      bank_r <= 3'd0;
      wnt_r <= 1'b0;
      ph_r <= PH_OPCODE;
      hop_r <= 8'd0;
      for (int i = 0; i < 16; i++) ix_r[i] <= 4'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_r[i] <= 12'd0;
    end else if (go) begin
      pc_r <= pc_nxt;
      sp_r <= sp_nxt;
      acc_r <= acc_nxt;
      cy_r <= cy_nxt;
      src_r <= src_nxt;
      bank_r <= bank_nxt;
      wnt_r <= wnt_nxt;
      ph_r <= ph_nxt;
      hop_r <= hop_nxt;
      ix_r <= ix_nxt;
      if (push) stk_r[sp_r] <= pc_r + 12'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_ch.valid <= 1'b0;
    else if (go) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
    if (go) begin
      out_ch.rom_address <= addr;
      out_ch.instruction_done <= done;
      out_ch.ram_port_write <= rampw;
      out_ch.ram_port_index <= {bank_nxt, src_nxt[7:6]};
      out_ch.rom_port_write <= rompw;
      out_ch.rom_port_index <= src_nxt[7:4];
      out_ch.port_data <= pdata;
      out_ch.rom_write <= romw;
      out_ch.rom_write_address <= romwa;
      out_ch.rom_write_data <= romwd;
      out_ch.accumulator <= acc_nxt;
      out_ch.carry <= cy_nxt;
    end
  end
endmodule

@@ rtl/core/nce_ram.sv @@
// Data and status RAM with registered reads and a clearing sweep after reset
module nce_ram #(
  parameter int RAM_BANKS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     rd_en,
  input  logic [$clog2(RAM_BANKS*256)-1:0]         d_addr,
  input  logic [$clog2(RAM_BANKS*64)-1:0]          s_addr,
  input  nce_pkg::ram_wr_t                         wr,
  input  logic [3:0]                               wr_data,
  output logic [3:0]                               d_q,
  output logic [3:0]                               s_q,
  output logic                                     busy
);
  import nce_pkg::*;

  localparam int D_DEPTH = RAM_BANKS * 256;
  localparam int S_DEPTH = RAM_BANKS * 64;
  localparam int DA_W = $clog2(D_DEPTH);
  localparam int SA_W = $clog2(S_DEPTH);

  logic [3:0]      dmem [D_DEPTH];
  logic [3:0]      smem [S_DEPTH];
  logic            clr_r;
  logic [DA_W-1:0] cnt_r;

  // Sweep every data entry once after reset, and each status entry four times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      cnt_r <= '0;
    end else if (clr_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DA_W'(D_DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  // Write ports: clear sweep or execute writes
  always_ff @(posedge clk) begin
    if (clr_r) begin
      dmem[cnt_r] <= 4'd0;
      smem[cnt_r[SA_W-1:0]] <= 4'd0;
    end else begin
      if (wr.dwe) dmem[d_addr] <= wr_data;
      if (wr.swe) smem[s_addr] <= wr_data;
    end
  end

  // Registered reads when a word is captured
  always_ff @(posedge clk) begin
    if (rd_en) begin
      d_q <= dmem[d_addr];
      s_q <= smem[s_addr];
    end
  end

  assign busy = clr_r;
endmodule

@@ rtl/core/nce_checker.sv @@
// Port checker for the core, attached by bind
`include "assert_macros.svh"

module nce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       done,
  input logic       rom_write,
  input logic       ram_pw,
  input logic       rom_pw,
  input logic [3:0] port_data
);
  `NCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `NCE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `NCE_ASSERT_SAME(a_wpm_done, clk, rst_n, out_valid && rom_write, done)
  `NCE_ASSERT_SAME(a_pdata_idle, clk, rst_n, out_valid && !ram_pw && !rom_pw, port_data == 4'd0)
endmodule

bind nibble_cpu_instruction_executor_core nce_checker u_nce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .done      (out_ch.instruction_done),
  .rom_write (out_ch.rom_write),
  .ram_pw    (out_ch.ram_port_write),
  .rom_pw    (out_ch.rom_port_write),
  .port_data (out_ch.port_data)
);
